>>> rtl/ohm_pkg.sv
// ============================================================================
// ohm_pkg
// Shared types and constants for the open-addressing hash map: request and
// result payloads, command and status codes, and the control/status bundles
// that pass between the controller and the datapath.
// ============================================================================
package ohm_pkg;

    // Table geometry
    localparam int CAPACITY   = 256;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int KEY_W      = 32;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = IDX_W + 1;
    localparam int LIMIT_W    = 8;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // Command codes
    localparam logic [1:0] CMD_PUT = 2'd0;
    localparam logic [1:0] CMD_GET = 2'd1;
    localparam logic [1:0] CMD_POP = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] default_value;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] result_value;
        logic [CNT_W-1:0] live_count;
    } result_t;

    // One stored slot; the non-empty flag lives in a separate valid vector
    typedef struct packed {
        logic             live;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic probe_next;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic probe_end;
    } dp_status_t;

endpackage

>>> rtl/ohm_ctrl.sv
// ============================================================================
// ohm_ctrl
// Controller for the hash map: takes a request, steps the probe one slot per
// cycle until the datapath reports the end, then commits.
// ============================================================================
module ohm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ohm_pkg::dp_status_t dp_status,
    output ohm_pkg::ctrl_cmd_t  ctrl_cmd,
    output logic                busy
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_PROBE = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next          = state_reg;
        ctrl_cmd.load       = 1'b0;
        ctrl_cmd.probe_next = 1'b0;
        ctrl_cmd.commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl_cmd.load = 1'b1;
                    state_next    = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (dp_status.probe_end)
                begin
                    ctrl_cmd.commit = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    ctrl_cmd.probe_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_PROBE);

endmodule

>>> rtl/ohm_dpath.sv
// ============================================================================
// ohm_dpath
// Datapath for the hash map: slot memory with registered read, non-empty
// valid bits, probe index and tombstone tracking, counters, and the result
// register.
// ============================================================================
module ohm_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  ohm_pkg::ctrl_cmd_t  ctrl_cmd,
    input  ohm_pkg::request_t   request,
    input  logic                cfg_we,
    input  logic [ohm_pkg::LIMIT_W-1:0] cfg_wdata,
    output ohm_pkg::dp_status_t dp_status,
    output ohm_pkg::result_t    result,
    output logic                done
);

    // Slot storage
    ohm_pkg::slot_t slot_mem [ohm_pkg::CAPACITY];
    ohm_pkg::slot_t rd_slot_reg;
    logic [ohm_pkg::CAPACITY-1:0] occ_vld_reg;
    logic rd_vld_reg;

    // Latched request
    logic [1:0]                cmd_reg;
    logic [ohm_pkg::KEY_W-1:0] key_reg;
    logic [ohm_pkg::VAL_W-1:0] val_reg;
    logic [ohm_pkg::VAL_W-1:0] dflt_reg;

    // Probe state
    logic [ohm_pkg::IDX_W-1:0] idx_reg;
    logic [ohm_pkg::IDX_W-1:0] step_reg;
    logic                      tomb_seen_reg;
    logic [ohm_pkg::IDX_W-1:0] tomb_idx_reg;

    // Counters and limit
    logic [ohm_pkg::CNT_W-1:0]   record_cnt_reg;
    logic [ohm_pkg::CNT_W-1:0]   record_cnt_next;
    logic [ohm_pkg::CNT_W-1:0]   occ_cnt_reg;
    logic [ohm_pkg::CNT_W-1:0]   occ_cnt_next;
    logic [ohm_pkg::LIMIT_W-1:0] limit_reg;

    // Output
    ohm_pkg::result_t result_reg;
    logic             done_reg;

    // Probe decode
    logic                      rd_en;
    logic [ohm_pkg::IDX_W-1:0] rd_addr;
    logic                      cur_empty;
    logic                      cur_tomb;
    logic                      cur_hit;
    logic                      cmd_valid;
    logic                      last_step;
    logic                      have_tomb;
    logic [ohm_pkg::IDX_W-1:0] tomb_at;

    // Commit decode
    logic                      wr_en;
    logic [ohm_pkg::IDX_W-1:0] wr_addr;
    ohm_pkg::slot_t            wr_slot;
    logic                      set_vld;
    logic [1:0]                status_c;
    logic [ohm_pkg::VAL_W-1:0] value_c;

    assign rd_en   = ctrl_cmd.load | ctrl_cmd.probe_next;
    assign rd_addr = ctrl_cmd.load ? request.key[ohm_pkg::IDX_W-1:0] : idx_reg + 1'b1;

    assign cmd_valid = (cmd_reg == ohm_pkg::CMD_PUT) || (cmd_reg == ohm_pkg::CMD_GET)
                    || (cmd_reg == ohm_pkg::CMD_POP);
    assign cur_empty = !rd_vld_reg;
    assign cur_tomb  = rd_vld_reg && !rd_slot_reg.live;
    assign cur_hit   = rd_vld_reg && rd_slot_reg.live && (rd_slot_reg.key == key_reg);
    assign last_step = (step_reg == ohm_pkg::IDX_W'(ohm_pkg::CAPACITY - 1));
    assign have_tomb = cur_tomb || tomb_seen_reg;
    assign tomb_at   = cur_tomb ? idx_reg : tomb_idx_reg;

    assign dp_status.probe_end = !cmd_valid || cur_empty || cur_hit || last_step;

    // Decide the outcome of the finished probe
    always_comb
    begin
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_slot         = '{live: 1'b1, key: key_reg, value: val_reg};
        set_vld         = 1'b0;
        status_c        = ohm_pkg::ST_ABSENT;
        value_c         = dflt_reg;
        record_cnt_next = record_cnt_reg;
        occ_cnt_next    = occ_cnt_reg;
        case (cmd_reg)
            ohm_pkg::CMD_PUT:
            begin
                value_c = '0;
                if (cur_hit)
                begin
                    wr_en    = 1'b1;
                    status_c = ohm_pkg::ST_OK;
                end
                else if (have_tomb)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = tomb_at;
                    record_cnt_next = record_cnt_reg + 1'b1;
                    status_c        = ohm_pkg::ST_OK;
                end
                else if (cur_empty &&
                         (occ_cnt_reg < {1'b0, limit_reg}))
                begin
                    wr_en           = 1'b1;
                    set_vld         = 1'b1;
                    record_cnt_next = record_cnt_reg + 1'b1;
                    occ_cnt_next    = occ_cnt_reg + 1'b1;
                    status_c        = ohm_pkg::ST_OK;
                end
                else
                begin
                    status_c = ohm_pkg::ST_FULL;
                end
            end
            ohm_pkg::CMD_GET:
            begin
                if (cur_hit)
                begin
                    value_c  = rd_slot_reg.value;
                    status_c = ohm_pkg::ST_OK;
                end
            end
            ohm_pkg::CMD_POP:
            begin
                if (cur_hit)
                begin
                    value_c  = rd_slot_reg.value;
                    status_c = ohm_pkg::ST_OK;
                    wr_en    = 1'b1;
                    wr_slot  = '{live: 1'b0, key: rd_slot_reg.key, value: rd_slot_reg.value};
                    if (record_cnt_reg != '0)
                    begin
                        record_cnt_next = record_cnt_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_c = ohm_pkg::ST_ABSENT;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.commit && wr_en)
        begin
            slot_mem[wr_addr] <= wr_slot;
        end
        if (rd_en)
        begin
            rd_slot_reg <= slot_mem[rd_addr];
        end
    end

    // Non-empty valid bits; reset marks every slot empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl_cmd.commit && set_vld)
            begin
                occ_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= occ_vld_reg[rd_addr];
            end
        end
    end

    // Request latch, probe walk and result register
    always_ff @(posedge clk)
    begin
        if (ctrl_cmd.load)
        begin
            cmd_reg       <= request.command;
            key_reg       <= request.key;
            val_reg       <= request.value;
            dflt_reg      <= request.default_value;
            idx_reg       <= request.key[ohm_pkg::IDX_W-1:0];
            step_reg      <= '0;
            tomb_seen_reg <= 1'b0;
        end
        else if (ctrl_cmd.probe_next)
        begin
            idx_reg  <= idx_reg + 1'b1;
            step_reg <= step_reg + 1'b1;
            if (cur_tomb)
            begin
                tomb_seen_reg <= 1'b1;
                tomb_idx_reg  <= idx_reg;
            end
        end
        if (ctrl_cmd.commit)
        begin
            result_reg.status       <= status_c;
            result_reg.result_value <= value_c;
            result_reg.live_count   <= record_cnt_next;
        end
    end

    // Counters, limit and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_cnt_reg <= '0;
            occ_cnt_reg    <= '0;
            limit_reg      <= ohm_pkg::LIMIT_RESET;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_cmd.commit;
            if (ctrl_cmd.commit)
            begin
                record_cnt_reg <= record_cnt_next;
                occ_cnt_reg    <= occ_cnt_next;
            end
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

>>> rtl/open_addressing_hash_map.sv
// ============================================================================
// open_addressing_hash_map
// Key/value map over 256 slots with linear probing and tombstones. Put,
// get and pop walk from the key's home slot (low key bits) one slot per
// cycle; put refuses a new slot once the occupancy limit is reached.
// ============================================================================
//
//  Channel   | Ports                         | Handshake
//  ----------+-------------------------------+---------------------------------
//  request   | start, busy, request          | taken when start && !busy
//  result    | done, result                  | one-cycle strobe, no stall
//  config    | cfg_we, cfg_wdata             | occupancy limit, written on cfg_we
//
//  Probing: a request reads one slot per cycle through the single read port
//  of the slot memory, walking between 1 and 256 slots; the result strobes
//  the cycle after the last probe, when busy has already dropped, and a
//  further request is taken no earlier than that strobe cycle.
//  Reset: rst_n clears every slot to empty at once through a valid-bit
//  vector, clears the counters and sets the limit to 128. No clearing pass.
//  Stalls: none; the receiver must take each result in its strobe cycle.
//
module open_addressing_hash_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  ohm_pkg::request_t            request,
    output logic                         done,
    output ohm_pkg::result_t             result,
    input  logic                         cfg_we,
    input  logic [ohm_pkg::LIMIT_W-1:0]  cfg_wdata
);

    ohm_pkg::ctrl_cmd_t  ctrl_cmd;
    ohm_pkg::dp_status_t dp_status;

    // Controller: hold in probe until the datapath reports that the probe has ended
    ohm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .dp_status (dp_status),
        .ctrl_cmd  (ctrl_cmd),
        .busy      (busy)
    );

    // Datapath: slot memory, probe walk, counters and result register
    ohm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_cmd  (ctrl_cmd),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .dp_status (dp_status),
        .result    (result),
        .done      (done)
    );

endmodule

>>> bench/open_addressing_hash_map_test.sv
`timescale 1ns / 100ps
// ============================================================================
// open_addressing_hash_map_test
// Self-checking bench for the linear-probing hash map. A directed table
// covers empty-map lookups, collisions, replacement, tombstone creation and
// reuse, the occupancy limit at three and zero, and the unused command.
// Random phases follow under limits that include zero, one and full scale.
// Each result is checked against a hand-written value or an in-bench model.
// ============================================================================
module open_addressing_hash_map_test;

    // The fourth command code has no name in the package; it must act as a miss
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_REQUESTS = 92;
    localparam int KEY_POOL_DEPTH = 64;

    typedef enum logic [1:0] {SLOT_EMPTY, SLOT_TOMB, SLOT_LIVE} slot_mark_t;

    // One row of the directed table: either a limit write or a request,
    // the latter with an optional hand-written expected result
    typedef struct packed {
        logic                        is_cfg;
        logic [ohm_pkg::LIMIT_W-1:0] limit;
        ohm_pkg::request_t           req;
        logic                        typed;
        ohm_pkg::result_t            want;
    } plan_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    ohm_pkg::request_t           request;
    logic                        done;
    ohm_pkg::result_t            result;
    logic                        cfg_we;
    logic [ohm_pkg::LIMIT_W-1:0] cfg_wdata;

    // Model of the slot table
    logic [ohm_pkg::KEY_W-1:0]   model_key  [ohm_pkg::CAPACITY];
    logic [ohm_pkg::VAL_W-1:0]   model_val  [ohm_pkg::CAPACITY];
    slot_mark_t                  model_mark [ohm_pkg::CAPACITY];
    logic [ohm_pkg::CNT_W-1:0]   model_live;
    logic [ohm_pkg::CNT_W-1:0]   model_used;
    logic [ohm_pkg::LIMIT_W-1:0] model_limit;

    ohm_pkg::result_t            awaited_results [$];
    logic [ohm_pkg::KEY_W-1:0]   key_pool [$];
    plan_row_t                   directed_plan [$];
    ohm_pkg::result_t            oldest;
    int                          faults;

    open_addressing_hash_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run: worst case is every request probing the whole table
    initial
    begin
        #6_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic log_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    // Walk the table from the home slot the way the block does, then apply
    // the command to the model and return the result it must produce
    task automatic map_command_outcome(input ohm_pkg::request_t req,
                                       output ohm_pkg::result_t res);
        logic [ohm_pkg::IDX_W-1:0] idx;
        logic [ohm_pkg::IDX_W-1:0] at;
        logic                      hit;
        logic                      have_slot;
        logic                      stop;
        int                        n;
        idx       = req.key[ohm_pkg::IDX_W-1:0];
        at        = '0;
        hit       = 1'b0;
        have_slot = 1'b0;
        stop      = 1'b0;
        res.status       = ohm_pkg::ST_ABSENT;
        res.result_value = req.default_value;
        if (req.command != CMD_UNUSED)
        begin
            for (n = 0; n < ohm_pkg::CAPACITY && !stop; n++)
            begin
                case (model_mark[idx])
                    SLOT_EMPTY:
                    begin
                        // keep the last tombstone if one was passed
                        if (!have_slot)
                        begin
                            have_slot = 1'b1;
                            at        = idx;
                        end
                        stop = 1'b1;
                    end
                    SLOT_TOMB:
                    begin
                        have_slot = 1'b1;
                        at        = idx;
                    end
                    default:
                    begin
                        if (model_key[idx] == req.key)
                        begin
                            hit       = 1'b1;
                            have_slot = 1'b0;
                            at        = idx;
                            stop      = 1'b1;
                        end
                    end
                endcase
                idx = idx + 1'b1;
            end
        end
        if (req.command == ohm_pkg::CMD_PUT)
        begin
            res.result_value = '0;
            if (hit)
            begin
                model_val[at] = req.value;
                res.status    = ohm_pkg::ST_OK;
            end
            else if (!have_slot)
                res.status = ohm_pkg::ST_FULL;
            else if (model_mark[at] == SLOT_TOMB)
            begin
                // tombstone reuse ignores the limit and keeps the used count
                model_key[at]  = req.key;
                model_val[at]  = req.value;
                model_mark[at] = SLOT_LIVE;
                model_live     = model_live + 1'b1;
                res.status     = ohm_pkg::ST_OK;
            end
            else if (model_used >= model_limit)
                res.status = ohm_pkg::ST_FULL;
            else
            begin
                model_key[at]  = req.key;
                model_val[at]  = req.value;
                model_mark[at] = SLOT_LIVE;
                model_live     = model_live + 1'b1;
                model_used     = model_used + 1'b1;
                res.status     = ohm_pkg::ST_OK;
            end
        end
        else if ((req.command == ohm_pkg::CMD_GET || req.command == ohm_pkg::CMD_POP)
                 && hit)
        begin
            res.result_value = model_val[at];
            res.status       = ohm_pkg::ST_OK;
            if (req.command == ohm_pkg::CMD_POP)
            begin
                model_mark[at] = SLOT_TOMB;
                if (model_live != 0)
                    model_live = model_live - 1'b1;
            end
        end
        res.live_count = model_live;
    endtask

    // Present one request after an optional idle gap and hold it until the block
    // takes it; return at the falling edge after the taking edge
    task automatic issue(input ohm_pkg::request_t req, input int gap,
                         input logic typed, input ohm_pkg::result_t want);
        ohm_pkg::result_t predicted;
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        request = req;
        start   = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        map_command_outcome(req, predicted);
        awaited_results.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // Write the limit only once the block has drained every request
    task automatic write_limit(input logic [ohm_pkg::LIMIT_W-1:0] lim);
        start = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        cfg_we      = 1'b1;
        cfg_wdata   = lim;
        model_limit = lim;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic plan_row_t req_row(input logic [1:0] cmd, input logic [31:0] k,
                                          input logic [31:0] v, input logic [31:0] d);
        plan_row_t row;
        row = '0;
        row.req.command       = cmd;
        row.req.key           = k;
        row.req.value         = v;
        row.req.default_value = d;
        return row;
    endfunction

    function automatic plan_row_t chk_row(input logic [1:0] cmd, input logic [31:0] k,
                                          input logic [31:0] v, input logic [31:0] d,
                                          input logic [1:0] st, input logic [31:0] rv,
                                          input int cnt);
        plan_row_t row;
        row = req_row(cmd, k, v, d);
        row.typed             = 1'b1;
        row.want.status       = st;
        row.want.result_value = rv;
        row.want.live_count   = cnt[ohm_pkg::CNT_W-1:0];
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [ohm_pkg::LIMIT_W-1:0] lim);
        plan_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.limit  = lim;
        return row;
    endfunction

    // Half the time reuse a key already put, else build a fresh one that
    // mostly lands in a narrow band of home slots to grow probe chains
    function automatic logic [ohm_pkg::KEY_W-1:0] pick_key();
        logic [23:0] hi;
        logic [7:0]  lo;
        if (key_pool.size() > 0 && $urandom_range(0, 9) < 5)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        case ($urandom_range(0, 2))
            0:       hi = 24'h000000;
            1:       hi = 24'hFFFFFF;
            default: hi = 24'($urandom);
        endcase
        lo = $urandom_range(0, 1) ? 8'($urandom_range(0, 23)) : 8'($urandom);
        return {hi, lo};
    endfunction

    // Check every strobed result against the oldest request still waiting
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_results.size() == 0)
                log_fault($sformatf("result with no request pending: %p", result));
            else
            begin
                oldest = awaited_results.pop_front();
                if (result.status !== oldest.status)
                    log_fault($sformatf("status: expected %0d, got %0d",
                                        oldest.status, result.status));
                if (result.result_value !== oldest.result_value)
                    log_fault($sformatf("result_value: expected %h, got %h",
                                        oldest.result_value, result.result_value));
                if (result.live_count !== oldest.live_count)
                    log_fault($sformatf("live_count: expected %0d, got %0d",
                                        oldest.live_count, result.live_count));
            end
        end
    end

    initial
    begin
        ohm_pkg::request_t           req;
        plan_row_t                   row;
        logic                        burst;
        logic [ohm_pkg::LIMIT_W-1:0] lim;
        int                          i;
        int                          k;
        int                          phase;
        int                          pick;
        faults    = 0;
        start     = 1'b0;
        request   = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        rst_n     = 1'b0;
        burst     = 1'b0;
        for (i = 0; i < ohm_pkg::CAPACITY; i++)
        begin
            model_key[i]  = '0;
            model_val[i]  = '0;
            model_mark[i] = SLOT_EMPTY;
        end
        model_live  = '0;
        model_used  = '0;
        model_limit = ohm_pkg::LIMIT_RESET;

        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty map, unused command, then put and hit at the field extremes
        directed_plan.push_back(chk_row(ohm_pkg::CMD_GET, 32'h0, 32'h0, 32'hFFFFFFFF,
                                        ohm_pkg::ST_ABSENT, 32'hFFFFFFFF, 0));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_POP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0,
                                        ohm_pkg::ST_ABSENT, 32'h0, 0));
        directed_plan.push_back(chk_row(CMD_UNUSED, 32'h12345678, 32'h9ABCDEF0,
                                        32'hA5A5A5A5, ohm_pkg::ST_ABSENT, 32'hA5A5A5A5, 0));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_PUT, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                        ohm_pkg::ST_OK, 32'h0, 1));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_GET, 32'h0, 32'h0, 32'h0,
                                        ohm_pkg::ST_OK, 32'hFFFFFFFF, 1));
        // Collision at slot zero, wrap slot, replacement
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h00000100, 32'h0, 32'h0));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_PUT, 32'hFFFFFFFF, 32'h12345678, 32'h0,
                                        ohm_pkg::ST_OK, 32'h0, 3));
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h0, 32'h5A5A5A5A, 32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_GET, 32'h00000100, 32'h0,
                                        32'hFFFFFFFF));
        // Pop leaves a tombstone; lookups walk past it; a put reuses it
        directed_plan.push_back(req_row(ohm_pkg::CMD_POP, 32'h0, 32'h0, 32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_GET, 32'h0, 32'h0, 32'h0F0F0F0F));
        directed_plan.push_back(req_row(ohm_pkg::CMD_GET, 32'h00000100, 32'h0, 32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h00000200, 32'hC3C3C3C3,
                                        32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_POP, 32'hFFFFFFFF, 32'h0, 32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_POP, 32'hFFFFFFFF, 32'h0,
                                        32'h3C3C3C3C));
        // Limit reached, yet a tombstone still takes a new key
        directed_plan.push_back(cfg_row(8'd3));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_PUT, 32'h00000055, 32'h11111111, 32'h0,
                                        ohm_pkg::ST_FULL, 32'h0, 2));
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h000001FF, 32'h22222222,
                                        32'h0));
        // Limit of zero: empty slots refused, hits and tombstones still work
        directed_plan.push_back(cfg_row(8'd0));
        directed_plan.push_back(chk_row(ohm_pkg::CMD_PUT, 32'h00000077, 32'h33333333, 32'h0,
                                        ohm_pkg::ST_FULL, 32'h0, 3));
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h00000100, 32'h44444444,
                                        32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_POP, 32'h00000100, 32'h0, 32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_PUT, 32'h00000300, 32'h55555555,
                                        32'h0));
        directed_plan.push_back(req_row(ohm_pkg::CMD_GET, 32'h00000300, 32'h0, 32'h0));

        for (i = 0; i < directed_plan.size(); i++)
        begin
            row = directed_plan[i];
            if (row.is_cfg)
                write_limit(row.limit);
            else
                issue(row.req, $urandom_range(0, 3), row.typed, row.want);
        end

        // Random phases: each opens with a new limit, including one just
        // above the current occupancy so refusals show up mid-phase
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       lim = 8'd255;
                1:       lim = (int'(model_used) + 8 > 255) ? 8'd255 : 8'(model_used + 8);
                2:       lim = 8'd1;
                3:       lim = 8'd0;
                4:       lim = 8'($urandom_range(1, 255));
                default: lim = 8'd255;
            endcase
            write_limit(lim);
            for (k = 0; k < PHASE_REQUESTS; k++)
            begin
                // switch between back-to-back stretches and gapped traffic
                if (k % 16 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                req.command       = (pick < 45) ? ohm_pkg::CMD_PUT :
                                    (pick < 70) ? ohm_pkg::CMD_GET :
                                    (pick < 95) ? ohm_pkg::CMD_POP : CMD_UNUSED;
                req.key           = pick_key();
                req.value         = $urandom;
                req.default_value = $urandom;
                if (req.command == ohm_pkg::CMD_PUT)
                begin
                    key_pool.push_back(req.key);
                    if (key_pool.size() > KEY_POOL_DEPTH)
                        void'(key_pool.pop_front());
                end
                issue(req, burst ? 0 : $urandom_range(0, 3), 1'b0, '0);
            end
        end

        // Drain: one request probes at most the whole table
        start = 1'b0;
        for (k = 0; k < 4 * ohm_pkg::CAPACITY && awaited_results.size() != 0; k++)
            @(posedge clk);
        if (awaited_results.size() != 0)
            log_fault($sformatf("%0d results never arrived", awaited_results.size()));
        repeat (8) @(posedge clk);

        if (faults == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
